### rtl/two_level_cache_lookup_top_macros.svh
// Assertion macros for the two-level cache lookup checker.
// Included by the checker file only.
`ifndef TWO_LEVEL_CACHE_LOOKUP_TOP_MACROS_SVH
`define TWO_LEVEL_CACHE_LOOKUP_TOP_MACROS_SVH
// Assert an implication under reset.
`define TLC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a plain condition every clock under reset.
`define TLC_CHECK(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

### rtl/tlc_pkg.sv
// Shared types and constants for the two-level cache lookup.
// No dependencies.
`timescale 1ns / 1ps
package tlc_pkg;
	localparam logic [2:0] OUT_NONE = 3'd0;
	localparam logic [2:0] OUT_RH   = 3'd1;
	localparam logic [2:0] OUT_RM   = 3'd2;
	localparam logic [2:0] OUT_WH   = 3'd3;
	localparam logic [2:0] OUT_WM   = 3'd4;
	localparam logic [5:0] LAT_L1   = 6'd7;
	localparam logic [5:0] LAT_L12  = 6'd19;
	localparam logic [5:0] LAT_ALL  = 6'd34;
	localparam logic [2:0] REG_L1_OFF = 3'd0;
	localparam logic [2:0] REG_L1_IDX = 3'd1;
	localparam logic [2:0] REG_L1_WAYS = 3'd2;
	localparam logic [2:0] REG_L2_OFF = 3'd3;
	localparam logic [2:0] REG_L2_IDX = 3'd4;
	localparam logic [2:0] REG_L2_WAYS = 3'd5;

	// Item passed from the front part to the back part.
	typedef struct packed {
		logic        is_write;
		logic [31:0] address;
	} req_t;
endpackage

### rtl/two_level_cache_lookup_top.sv
// Two-level cache tag lookup with round-robin fill.
// An L1 hit runs the L1 tag scan, then the result; a write that misses L1 adds the L2 tag scan;
// a read that misses L1 adds the L2 tag scan and a fill. One request at a time; the tag scans,
// one way a cycle, set the rate. A two-beat queue takes requests while the back part works.
// Reset: registers take their defaults; a clearing pass over the larger of L1_MAX_SETS
// and L2_MAX_SETS sets clears valid bits and pointers before the first request starts.
`timescale 1ns / 1ps
module two_level_cache_lookup_top import tlc_pkg::*; #(
	parameter int L1_MAX_SETS = 256,
	parameter int L1_MAX_WAYS = 8,
	parameter int L2_MAX_SETS = 1024,
	parameter int L2_MAX_WAYS = 16,
	parameter int ADDRESS_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // address[31:0]
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // l1_outcome[2:0], l2_outcome[5:3], access_latency[11:6]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [4:0] l1_off_q, l2_off_q, l2_ways_q;
	logic [3:0] l1_idx_q, l1_ways_q, l2_idx_q;
	logic q_valid, q_pop;
	req_t in_req, q_req;
	logic [2:0] o1, o2;
	logic [5:0] lat;
	logic [2:0] reg_sel;

	assign pready = 1'b1;
	assign reg_sel = paddr[4:2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_off_q <= 5'd6; l1_idx_q <= 4'd6; l1_ways_q <= 4'd4;
			l2_off_q <= 5'd6; l2_idx_q <= 4'd8; l2_ways_q <= 5'd8;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_L1_OFF:  l1_off_q <= pwdata[4:0];
				REG_L1_IDX:  l1_idx_q <= pwdata[3:0];
				REG_L1_WAYS: l1_ways_q <= pwdata[3:0];
				REG_L2_OFF:  l2_off_q <= pwdata[4:0];
				REG_L2_IDX:  l2_idx_q <= pwdata[3:0];
				REG_L2_WAYS: l2_ways_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_sel)
			REG_L1_OFF:  prdata = {27'd0, l1_off_q};
			REG_L1_IDX:  prdata = {28'd0, l1_idx_q};
			REG_L1_WAYS: prdata = {28'd0, l1_ways_q};
			REG_L2_OFF:  prdata = {27'd0, l2_off_q};
			REG_L2_IDX:  prdata = {28'd0, l2_idx_q};
			REG_L2_WAYS: prdata = {27'd0, l2_ways_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign in_req.is_write = s_axis_tuser;
	assign in_req.address = s_axis_tdata;

	tlc_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_req, .q_valid, .q_pop, .q_req);

	tlc_back #(.L1_MAX_SETS(L1_MAX_SETS), .L1_MAX_WAYS(L1_MAX_WAYS),
		.L2_MAX_SETS(L2_MAX_SETS), .L2_MAX_WAYS(L2_MAX_WAYS),
		.ADDRESS_BITS(ADDRESS_BITS)) u_back (.clk, .arst_n, .q_valid, .q_pop, .q_req,
		.l1_off(l1_off_q), .l1_idx(l1_idx_q), .l1_ways(l1_ways_q),
		.l2_off(l2_off_q), .l2_idx(l2_idx_q), .l2_ways(l2_ways_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .o1, .o2, .lat);

	assign m_axis_tdata = {4'd0, lat, o2, o1};
endmodule

### rtl/tlc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/tlc_front.sv
// Front part: takes request beats into a two-entry queue.
// Depends on tlc_pkg.
`timescale 1ns / 1ps
module tlc_front import tlc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_req,
	output logic        q_valid,
	input  logic        q_pop,
	output req_t        q_req
);
	req_t       buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = buf_q[rd_q];

	// Store payload.
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_req;
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### rtl/tlc_back.sv
// Back part: tag lookup, allocation and result register.
// Depends on tlc_pkg and tlc_ram.
`timescale 1ns / 1ps
module tlc_back import tlc_pkg::*; #(
	parameter int L1_MAX_SETS = 256,
	parameter int L1_MAX_WAYS = 8,
	parameter int L2_MAX_SETS = 1024,
	parameter int L2_MAX_WAYS = 16,
	parameter int ADDRESS_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  req_t        q_req,
	input  logic [4:0]  l1_off,
	input  logic [3:0]  l1_idx,
	input  logic [3:0]  l1_ways,
	input  logic [4:0]  l2_off,
	input  logic [3:0]  l2_idx,
	input  logic [4:0]  l2_ways,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  o1,
	output logic [2:0]  o2,
	output logic [5:0]  lat
);
	localparam int S1W = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
	localparam int S2W = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
	localparam int W1W = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
	localparam int W2W = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
	localparam int C1W = $clog2(L1_MAX_WAYS + 1);
	localparam int C2W = $clog2(L2_MAX_WAYS + 1);
	localparam int I1CAP = (S1W > 8 || L1_MAX_SETS < 2) ? ((L1_MAX_SETS < 2) ? 0 : 8)
		: $clog2(L1_MAX_SETS + 1) - 1;
	localparam int I2CAP = (S2W > 10 || L2_MAX_SETS < 2) ? ((L2_MAX_SETS < 2) ? 0 : 10)
		: $clog2(L2_MAX_SETS + 1) - 1;
	localparam int D1 = L1_MAX_SETS * L1_MAX_WAYS;
	localparam int D2 = L2_MAX_SETS * L2_MAX_WAYS;
	localparam int A1 = (D1 > 1) ? $clog2(D1) : 1;
	localparam int A2 = (D2 > 1) ? $clog2(D2) : 1;
	localparam int NCLR = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
	localparam int SCW = (NCLR > 1) ? $clog2(NCLR) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_L1   = 3'd1;
	localparam logic [2:0] ST_L2   = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_CLR  = 3'd5;

	logic [2:0] state_q;
	logic [C1W-1:0] w1_q, k1_q;
	logic [C2W-1:0] w2_q, k2_q;
	logic [S1W-1:0] s1_q;
	logic [S2W-1:0] s2_q;
	logic [31:0] t1_q, t2_q;
	logic wr_q, hit1_q, hit2_q, free1_q, free2_q;
	logic [W1W-1:0] pk1_q, free1w_q;
	logic [W2W-1:0] pk2_q, free2w_q;
	logic [L1_MAX_WAYS-1:0] v1_row;
	logic [L2_MAX_WAYS-1:0] v2_row;
	logic [SCW-1:0] clr_q;

	// Valid bits and pointers of both levels live in RAM, cleared by a sweep after reset.
	logic v1_we;
	logic [S1W-1:0] v1_wa, v1_ra;
	logic [L1_MAX_WAYS+W1W-1:0] v1_wd, v1_rd;
	logic v2_we;
	logic [S2W-1:0] v2_wa;
	logic [L2_MAX_WAYS+W2W-1:0] v2_wd, v2_rd;

	// Tag RAMs.
	logic t1_we, t2_we;
	logic [A1-1:0] t1_wa, t1_ra;
	logic [A2-1:0] t2_wa, t2_ra;
	logic [31:0] t1_rd, t2_rd;
	logic [31:0] t1_wd, t2_wd;

	tlc_ram #(.WIDTH(32), .DEPTH(D1)) u_tag1 (.clk, .we(t1_we), .waddr(t1_wa),
		.wdata(t1_wd), .raddr(t1_ra), .rdata(t1_rd));
	tlc_ram #(.WIDTH(32), .DEPTH(D2)) u_tag2 (.clk, .we(t2_we), .waddr(t2_wa),
		.wdata(t2_wd), .raddr(t2_ra), .rdata(t2_rd));
	tlc_ram #(.WIDTH(L2_MAX_WAYS + W2W), .DEPTH(L2_MAX_SETS)) u_vld2 (.clk, .we(v2_we),
		.waddr(v2_wa), .wdata(v2_wd), .raddr(s2_q), .rdata(v2_rd));

	// Address split and config clamps for the head of queue.
	logic [63:0] a64;
	logic [4:0] o1c, o2c;
	logic [3:0] i1c, i2c;
	logic [S1W-1:0] s1_n;
	logic [S2W-1:0] s2_n;
	logic [31:0] t1_n, t2_n;
	always_comb begin
		a64 = {32'd0, q_req.address};
		if (ADDRESS_BITS < 64) a64 = a64 & ((64'd1 << ADDRESS_BITS) - 64'd1);
		o1c = (l1_off > 5'd16) ? 5'd16 : l1_off;
		o2c = (l2_off > 5'd16) ? 5'd16 : l2_off;
		i1c = (l1_idx > 4'(I1CAP)) ? 4'(I1CAP) : l1_idx;
		i2c = (l2_idx > 4'(I2CAP)) ? 4'(I2CAP) : l2_idx;
		s1_n = S1W'((a64 >> o1c) & ((64'd1 << i1c) - 64'd1));
		s2_n = S2W'((a64 >> o2c) & ((64'd1 << i2c) - 64'd1));
		t1_n = 32'(a64 >> ({1'b0, o1c} + {2'b0, i1c}));
		t2_n = 32'(a64 >> ({1'b0, o2c} + {2'b0, i2c}));
	end

	// Read the L1 row for the head of queue while idle, so it is ready in the first scan cycle.
	assign v1_ra = (state_q == ST_IDLE) ? s1_n : s1_q;

	tlc_ram #(.WIDTH(L1_MAX_WAYS + W1W), .DEPTH(L1_MAX_SETS)) u_vld1 (.clk, .we(v1_we),
		.waddr(v1_wa), .wdata(v1_wd), .raddr(v1_ra), .rdata(v1_rd));

	// Way counts in use.
	logic [C1W-1:0] w1c;
	logic [C2W-1:0] w2c;
	always_comb begin
		if (l1_ways == 4'd0) w1c = C1W'(1);
		else if (32'(l1_ways) > L1_MAX_WAYS) w1c = C1W'(L1_MAX_WAYS);
		else w1c = C1W'(l1_ways);
		if (l2_ways == 5'd0) w2c = C2W'(1);
		else if (32'(l2_ways) > L2_MAX_WAYS) w2c = C2W'(L2_MAX_WAYS);
		else w2c = C2W'(l2_ways);
	end

	assign v1_row = v1_rd[L1_MAX_WAYS-1:0];
	assign v2_row = v2_rd[L2_MAX_WAYS-1:0];
	assign t1_ra = A1'({s1_q, W1W'(k1_q)});
	assign t2_ra = A2'({s2_q, W2W'(k2_q)});

	// Read-port data arrives in the cycle after the scan counter addresses it.
	logic [W1W-1:0] kd1_q;
	logic [W2W-1:0] kd2_q;
	logic rv_q;

	// Victim choice per level: first free at or after the pointer, wrapping, else the pointer's way.
	logic [W1W-1:0] vic1;
	logic [W2W-1:0] vic2;
	always_comb begin
		vic1 = free1_q ? free1w_q : pk1_q;
		vic2 = free2_q ? free2w_q : pk2_q;
	end

	// Free-way position rank relative to pointer, for the scan.
	function automatic logic before1(input logic [W1W-1:0] a, input logic [W1W-1:0] b,
		input logic [W1W-1:0] p);
		logic aw, bw;
		aw = a < p;
		bw = b < p;
		return (aw == bw) ? (a < b) : bw;
	endfunction
	function automatic logic before2(input logic [W2W-1:0] a, input logic [W2W-1:0] b,
		input logic [W2W-1:0] p);
		logic aw, bw;
		aw = a < p;
		bw = b < p;
		return (aw == bw) ? (a < b) : bw;
	endfunction

	logic [W1W-1:0] p1r;
	logic [W2W-1:0] p2r;
	assign p1r = (C1W'(v1_rd[L1_MAX_WAYS+W1W-1:L1_MAX_WAYS]) >= w1_q) ? '0
		: v1_rd[L1_MAX_WAYS+W1W-1:L1_MAX_WAYS];
	assign p2r = (C2W'(v2_rd[L2_MAX_WAYS+W2W-1:L2_MAX_WAYS]) >= w2_q) ? '0
		: v2_rd[L2_MAX_WAYS+W2W-1:L2_MAX_WAYS];

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign out_valid = (state_q == ST_OUT);

	// Fill writes and clearing-sweep writes.
	logic [W1W-1:0] nx1;
	logic [W2W-1:0] nx2;
	always_comb begin
		nx1 = (C1W'(vic1) + C1W'(1) >= w1_q) ? '0 : W1W'(C1W'(vic1) + C1W'(1));
		nx2 = (C2W'(vic2) + C2W'(1) >= w2_q) ? '0 : W2W'(C2W'(vic2) + C2W'(1));
		t1_we = (state_q == ST_FILL);
		t1_wa = A1'({s1_q, vic1});
		t1_wd = t1_q;
		t2_we = (state_q == ST_FILL) && !hit2_q;
		t2_wa = A2'({s2_q, vic2});
		t2_wd = t2_q;
		v1_we = (state_q == ST_CLR) || t1_we;
		v1_wa = (state_q == ST_CLR) ? S1W'(clr_q) : s1_q;
		v1_wd = (state_q == ST_CLR) ? '0
			: {nx1, v1_row | (L1_MAX_WAYS'(1) << vic1)};
		v2_we = (state_q == ST_CLR) || t2_we;
		v2_wa = (state_q == ST_CLR) ? S2W'(clr_q) : s2_q;
		v2_wd = (state_q == ST_CLR) ? '0
			: {nx2, v2_row | (L2_MAX_WAYS'(1) << vic2)};
	end

	// Sequencer: clearing sweep after reset, then per request L1 tag scan, L2 tag scan, fill, hold result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			rv_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + SCW'(1);
					if (32'(clr_q) == NCLR - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) state_q <= ST_L1;
					rv_q <= 1'b0;
				end
				ST_L1: begin
					rv_q <= (k1_q < w1_q);
					if (k1_q >= w1_q && !rv_q) begin
						state_q <= (hit1_q) ? ST_OUT : ST_L2;
					end
				end
				ST_L2: begin
					rv_q <= (k2_q < w2_q);
					if (k2_q >= w2_q && !rv_q) begin
						state_q <= (wr_q) ? ST_OUT : ST_FILL;
					end
				end
				ST_FILL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				wr_q <= q_req.is_write;
				s1_q <= s1_n;
				s2_q <= s2_n;
				t1_q <= t1_n;
				t2_q <= t2_n;
				w1_q <= w1c;
				w2_q <= w2c;
				k1_q <= '0;
				k2_q <= '0;
				hit1_q <= 1'b0;
				hit2_q <= 1'b0;
				free1_q <= 1'b0;
				free2_q <= 1'b0;
			end
			ST_L1: begin
				if (rv_q && v1_row[kd1_q] && t1_rd == t1_q) hit1_q <= 1'b1;
				if (k1_q == '0) pk1_q <= p1r;
				if (k1_q < w1_q) begin
					k1_q <= k1_q + C1W'(1);
					kd1_q <= W1W'(k1_q);
					if (!v1_row[W1W'(k1_q)] && (!free1_q
						|| before1(W1W'(k1_q), free1w_q, p1r))) begin
						free1_q <= 1'b1;
						free1w_q <= W1W'(k1_q);
					end
				end
			end
			ST_L2: begin
				if (rv_q && v2_row[kd2_q] && t2_rd == t2_q) hit2_q <= 1'b1;
				if (k2_q == '0) pk2_q <= p2r;
				if (k2_q < w2_q) begin
					k2_q <= k2_q + C2W'(1);
					kd2_q <= W2W'(k2_q);
					if (!v2_row[W2W'(k2_q)] && (!free2_q
						|| before2(W2W'(k2_q), free2w_q, p2r))) begin
						free2_q <= 1'b1;
						free2w_q <= W2W'(k2_q);
					end
				end
			end
			default: ;
		endcase
	end

	// Result fields.
	always_comb begin
		if (hit1_q) begin
			o1 = wr_q ? OUT_WH : OUT_RH;
			o2 = OUT_NONE;
			lat = LAT_L1;
		end else if (hit2_q) begin
			o1 = wr_q ? OUT_WM : OUT_RM;
			o2 = wr_q ? OUT_WH : OUT_RH;
			lat = wr_q ? LAT_L1 : LAT_L12;
		end else begin
			o1 = wr_q ? OUT_WM : OUT_RM;
			o2 = wr_q ? OUT_WM : OUT_RM;
			lat = wr_q ? LAT_L12 : LAT_ALL;
		end
	end
endmodule

### rtl/tlc_checker.sv
// Port-level checker for the two-level cache lookup, bound to the top level.
// Depends on tlc_pkg and the macros header.
`timescale 1ns / 1ps
`include "two_level_cache_lookup_top_macros.svh"
module tlc_checker import tlc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        pready
);
	`TLC_ASSERT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result beat dropped")
	`TLC_CHECK(a_rdy, clk, arst_n, pready, "pready low")
	`TLC_ASSERT(a_none, clk, arst_n, m_axis_tvalid && m_axis_tdata[5:3] == OUT_NONE |-> m_axis_tdata[11:6] == LAT_L1, "L1 hit latency wrong")
	`TLC_ASSERT(a_l1, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[2:0] != OUT_NONE, "L1 outcome missing")
endmodule

bind two_level_cache_lookup_top tlc_checker u_chk (.clk, .arst_n, .m_axis_tvalid,
	.m_axis_tready, .m_axis_tdata, .pready);

### tb/tb_two_level_cache_lookup_top.sv
// Testbench for two_level_cache_lookup_top: streams reads and writes, predicts outcome codes
// and latency with its own tag and round-robin model, and checks every result beat.
// Depends on tlc_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb_two_level_cache_lookup_top;
	import tlc_pkg::*;

	localparam int L1_SETS = 256;
	localparam int L1_WAYS_MAX = 8;
	localparam int L2_SETS = 1024;
	localparam int L2_WAYS_MAX = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	// Packed from the top bit down, so l1_code lands in the lowest bits
	typedef struct packed {
		logic [5:0] latency;
		logic [2:0] l2_code;
		logic [2:0] l1_code;
	} outcome_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // address[31:0]
	logic        s_axis_tuser = 0;   // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;       // l1_outcome[2:0], l2_outcome[5:3], access_latency[11:6]
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	two_level_cache_lookup_top uut (.*);

	always #5 clk = ~clk;

	// Shadow configuration and tag stores
	logic [4:0] cfg_l1_off, cfg_l2_off, cfg_l2_ways;
	logic [3:0] cfg_l1_idx, cfg_l1_ways, cfg_l2_idx;
	logic [31:0] l1_tag [L1_SETS][L1_WAYS_MAX];
	logic        l1_vld [L1_SETS][L1_WAYS_MAX];
	logic [2:0]  l1_rr  [L1_SETS];
	logic [31:0] l2_tag [L2_SETS][L2_WAYS_MAX];
	logic        l2_vld [L2_SETS][L2_WAYS_MAX];
	logic [3:0]  l2_rr  [L2_SETS];

	req_t     pending_q [$];
	outcome_t expected_q [$];
	bit       failed = 0;
	bit       calm = 0;
	int       accepted_in = 0;
	int       cycles = 0;

	function automatic int index_bits(int v, int cap);
		return (v > cap) ? cap : v;
	endfunction

	function automatic int ways_used(int v, int cap);
		if (v == 0)
			return 1;
		return (v > cap) ? cap : v;
	endfunction

	// Compute outcome of one access and apply fills
	function automatic outcome_t cache_access(logic is_wr, logic [31:0] addr);
		outcome_t r;
		int i1, i2, w1, w2, o1, o2, s1, s2, w, k, p, pick;
		logic [63:0] a;
		logic [31:0] t1, t2;
		bit h1, h2;
		i1 = index_bits(cfg_l1_idx, 8);
		i2 = index_bits(cfg_l2_idx, 10);
		w1 = ways_used(cfg_l1_ways, L1_WAYS_MAX);
		w2 = ways_used(cfg_l2_ways, L2_WAYS_MAX);
		o1 = (cfg_l1_off > 16) ? 16 : cfg_l1_off;
		o2 = (cfg_l2_off > 16) ? 16 : cfg_l2_off;
		a = {32'd0, addr};
		s1 = int'((a >> o1) & ((64'd1 << i1) - 1));
		t1 = 32'(a >> (o1 + i1));
		s2 = int'((a >> o2) & ((64'd1 << i2) - 1));
		t2 = 32'(a >> (o2 + i2));
		h1 = 0;
		h2 = 0;
		for (w = 0; w < w1; w++)
			if (l1_vld[s1][w] && l1_tag[s1][w] == t1)
				h1 = 1;
		if (!h1)
			for (w = 0; w < w2; w++)
				if (l2_vld[s2][w] && l2_tag[s2][w] == t2)
					h2 = 1;
		if (h1) begin
			r.l1_code = is_wr ? OUT_WH : OUT_RH;
			r.l2_code = OUT_NONE;
			r.latency = LAT_L1;
		end else if (h2) begin
			r.l1_code = is_wr ? OUT_WM : OUT_RM;
			r.l2_code = is_wr ? OUT_WH : OUT_RH;
			r.latency = is_wr ? LAT_L1 : LAT_L12;
		end else begin
			r.l1_code = is_wr ? OUT_WM : OUT_RM;
			r.l2_code = is_wr ? OUT_WM : OUT_RM;
			r.latency = is_wr ? LAT_L12 : LAT_ALL;
		end
		// Fill on read miss: first free way from the pointer, else the pointer's way
		if (!is_wr && !h1) begin
			if (!h2) begin
				p = (l2_rr[s2] >= w2) ? 0 : l2_rr[s2];
				pick = p;
				for (k = w2 - 1; k >= 0; k--)
					if (!l2_vld[s2][(p + k) % w2])
						pick = (p + k) % w2;
				l2_tag[s2][pick] = t2;
				l2_vld[s2][pick] = 1;
				l2_rr[s2] = 4'((pick + 1) % w2);
			end
			p = (l1_rr[s1] >= w1) ? 0 : l1_rr[s1];
			pick = p;
			for (k = w1 - 1; k >= 0; k--)
				if (!l1_vld[s1][(p + k) % w1])
					pick = (p + k) % w1;
			l1_tag[s1][pick] = t1;
			l1_vld[s1][pick] = 1;
			l1_rr[s1] = 3'((pick + 1) % w1);
		end
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Input driver: keep tvalid high across back-to-back beats
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			in_gap = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (in_gap > 0) begin
				in_gap--;
				s_axis_tvalid <= 0;
			end else if (pending_q.size() > 0) begin
				req_t it;
				it = pending_q.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tuser <= it.is_write;
				s_axis_tdata <= it.address;
				in_gap = gap_len();
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// Predict on each accepted input beat
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_q.push_back(cache_access(s_axis_tuser, s_axis_tdata));
			accepted_in++;
		end
	end

	// Receiver: random stalls, plus one long hold-off to back up the block
	int out_gap = 0;
	int hold_left = 0;
	bit held = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 0;
		end else if (!held && accepted_in >= 60) begin
			held = 1;
			hold_left = 400;
			m_axis_tready <= 0;
		end else if (out_gap > 0) begin
			out_gap--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
			out_gap = gap_len();
		end
	end

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			outcome_t got, want;
			got = outcome_t'(m_axis_tdata[11:0]);
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				failed = 1;
			end else begin
				want = expected_q.pop_front();
				if (got.l1_code !== want.l1_code) begin
					$display("%0t: l1_outcome expected %0d actual %0d",
						$time, want.l1_code, got.l1_code);
					failed = 1;
				end
				if (got.l2_code !== want.l2_code) begin
					$display("%0t: l2_outcome expected %0d actual %0d",
						$time, want.l2_code, got.l2_code);
					failed = 1;
				end
				if (got.latency !== want.latency) begin
					$display("%0t: access_latency expected %0d actual %0d",
						$time, want.latency, got.latency);
					failed = 1;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 5'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_L1_OFF: cfg_l1_off = val[4:0];
			REG_L1_IDX: cfg_l1_idx = val[3:0];
			REG_L1_WAYS: cfg_l1_ways = val[3:0];
			REG_L2_OFF: cfg_l2_off = val[4:0];
			REG_L2_IDX: cfg_l2_idx = val[3:0];
			REG_L2_WAYS: cfg_l2_ways = val[4:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(int a, int b, int c, int d, int e, int f);
		reg_write(REG_L1_OFF, a);
		reg_write(REG_L1_IDX, b);
		reg_write(REG_L1_WAYS, c);
		reg_write(REG_L2_OFF, d);
		reg_write(REG_L2_IDX, e);
		reg_write(REG_L2_WAYS, f);
	endtask

	task automatic push_req(logic is_wr, logic [31:0] addr);
		req_t it;
		it.is_write = is_wr;
		it.address = addr;
		pending_q.push_back(it);
	endtask

	task automatic wait_idle();
		wait (pending_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly reads that revisit a small address pool, so hits, fills and evictions occur
	task automatic random_phase(int count);
		logic [31:0] pool [16];
		logic [31:0] a;
		int r;
		for (int i = 0; i < 16; i++)
			pool[i] = $urandom();
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			a = pool[$urandom_range(0, 15)];
			if ($urandom_range(0, 1))
				a[5:0] = 6'($urandom());
			if (r < 65)
				push_req(0, a);
			else if (r < 80)
				push_req(1, a);
			else
				push_req(1'($urandom()), $urandom());
		end
	endtask

	initial begin
		cfg_l1_off = 6; cfg_l1_idx = 6; cfg_l1_ways = 4;
		cfg_l2_off = 6; cfg_l2_idx = 8; cfg_l2_ways = 8;
		foreach (l1_vld[s, w]) begin
			l1_vld[s][w] = 0;
			l1_tag[s][w] = '0;
		end
		foreach (l2_vld[s, w]) begin
			l2_vld[s][w] = 0;
			l2_tag[s][w] = '0;
		end
		foreach (l1_rr[s]) l1_rr[s] = '0;
		foreach (l2_rr[s]) l2_rr[s] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// Directed: double miss, L1 hit, write hit and miss, set overflow and eviction
		calm = 1;
		push_req(0, 32'h0000_0000);
		push_req(0, 32'h0000_0000);
		push_req(1, 32'h0000_0000);
		push_req(1, 32'hFFFF_FFFF);
		push_req(0, 32'hFFFF_FFFF);
		push_req(0, 32'hFFFF_FFC0);
		for (int k = 1; k <= 6; k++)
			push_req(0, k << 12);
		push_req(0, 32'h0000_1000);
		push_req(1, 32'h0000_2000);
		push_req(1, 32'h0000_3000);
		push_req(1, 32'h0000_5000);
		wait_idle();
		calm = 0;

		// Extremes: single way, single set, byte blocks; out-of-list address ignored
		set_geometry(0, 0, 1, 0, 0, 1);
		reg_write(3'd6, 32'hFFFF_FFFF);
		push_req(0, 32'h1234_5678);
		push_req(0, 32'h1234_5679);
		push_req(0, 32'h1234_5678);
		push_req(1, 32'h1234_5679);
		random_phase(80);
		wait_idle();

		// Largest geometry
		set_geometry(16, 8, 8, 16, 10, 16);
		random_phase(90);
		wait_idle();

		// Over-range values that saturate, ways zero taken as one
		set_geometry(31, 15, 0, 31, 15, 0);
		random_phase(60);
		wait_idle();
		set_geometry(31, 15, 15, 31, 15, 31);
		random_phase(60);
		wait_idle();

		// Back to defaults with stale contents kept, then a mid geometry
		set_geometry(6, 6, 4, 6, 8, 8);
		calm = 1;
		random_phase(60);
		wait_idle();
		calm = 0;
		set_geometry(4, 3, 2, 5, 4, 3);
		random_phase(80);
		wait_idle();

		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+rtl
rtl/tlc_pkg.sv
rtl/tlc_ram.sv
rtl/tlc_front.sv
rtl/tlc_back.sv
rtl/two_level_cache_lookup_top.sv
rtl/tlc_checker.sv
tb/tb_two_level_cache_lookup_top.sv
